// File: design/ccu_pkg.sv
`timescale 1ns / 1ps
package ccu_pkg;

    localparam int CCU_MAX_N = 64;

    localparam int ACC_W  = 64;
    localparam int FAC_W  = 8;
    localparam int PROD_W = ACC_W + FAC_W;

    localparam logic [1:0] OP_PERM     = 2'd0;
    localparam logic [1:0] OP_POWER    = 2'd1;
    localparam logic [1:0] OP_COMB     = 2'd2;
    localparam logic [1:0] OP_MULTISET = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INVALID  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_STEP,
        S_WAIT,
        S_FINISH
    } ccu_state_t;

    typedef struct packed
    {
        logic             start;
        logic [ACC_W-1:0] acc;
        logic [FAC_W-1:0] factor;
        logic [FAC_W-1:0] divisor;
    } md_req_t;

    typedef struct packed
    {
        logic              done;
        logic [PROD_W-1:0] quot;
    } md_rsp_t;

endpackage

// File: design/combinatorial_count_unit.sv
`timescale 1ns / 1ps
// Each word runs S multiply/divide steps, S = r for opcodes 0 and 1 and
// min(r, m-r) for the binomials; an overflow ends the steps early and an invalid
// word goes straight to the output. Each step is a multiply and a divide on the
// muldiv unit, then a return to the sequencer's step state.
// One word in flight: in_ready rises with out_valid, so no new word is taken
// while one is being counted. Async active-low reset to idle.
module combinatorial_count_unit
#(
    parameter int MAX_N = ccu_pkg::CCU_MAX_N
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [6:0]  n_items,
    input  logic [6:0]  r_chosen,
    input  logic [1:0]  opcode,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] count,
    output logic [1:0]  status
);
    import ccu_pkg::*;

    ccu_state_t state_reg, state_next;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [FAC_W-1:0] factor_reg, factor_next;
    logic [FAC_W-1:0] divisor_reg, divisor_next;
    logic [FAC_W-1:0] steps_reg, steps_next;
    logic             fac_up_reg, fac_up_next;
    logic             fac_dn_reg, fac_dn_next;
    logic             div_up_reg, div_up_next;
    logic [1:0]       fin_status_reg, fin_status_next;
    logic             out_valid_reg, out_valid_next;
    logic [63:0]      count_reg, count_next;
    logic [1:0]       status_reg, status_next;

    logic [FAC_W-1:0] n8, r8, m_sel, mk, k_sel;
    logic             invalid, accept, out_free, overflow;
    md_req_t          md_req;
    md_rsp_t          md_rsp;

    assign n8       = {1'b0, n_items};
    assign r8       = {1'b0, r_chosen};
    assign invalid  = (n8 > FAC_W'(MAX_N)) || (r8 > FAC_W'(MAX_N)) || (r8 > n8);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign overflow = md_rsp.quot[PROD_W-1:ACC_W] != '0;

    // binomial setup: C(m,k) with k folded to min(k, m-k); for multisets
    // m = n+r-1 and m-k = n-1 (n = 0 allows only r = 0, so k is 0, giving 1)
    assign m_sel = (opcode == OP_MULTISET) ? (n8 + r8 - 1'b1) : n8;
    assign mk    = (opcode == OP_MULTISET) ? (n8 - 1'b1) : (n8 - r8);
    assign k_sel = (r8 > mk) ? mk : r8;

    ccu_muldiv u_muldiv
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = invalid ? S_FINISH : S_STEP;
            end
            S_STEP:
            begin
                state_next = (steps_reg == '0) ? S_FINISH : S_WAIT;
            end
            S_WAIT:
            begin
                if (md_rsp.done)
                    state_next = overflow ? S_FINISH : S_STEP;
            end
            S_FINISH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        acc_next        = acc_reg;
        factor_next     = factor_reg;
        divisor_next    = divisor_reg;
        steps_next      = steps_reg;
        fac_up_next     = fac_up_reg;
        fac_dn_next     = fac_dn_reg;
        div_up_next     = div_up_reg;
        fin_status_next = fin_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        count_next      = count_reg;
        status_next     = status_reg;
        in_ready        = (state_reg == S_IDLE);
        md_req.start    = (state_reg == S_STEP) && (steps_reg != '0);
        md_req.acc      = acc_reg;
        md_req.factor   = factor_reg;
        md_req.divisor  = divisor_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    acc_next     = ACC_W'(1);
                    divisor_next = FAC_W'(1);
                    fac_up_next  = 1'b0;
                    fac_dn_next  = 1'b0;
                    div_up_next  = 1'b0;
                    if (invalid)
                    begin
                        acc_next        = '0;
                        fin_status_next = ST_INVALID;
                    end
                    else
                    begin
                        fin_status_next = ST_OK;
                        case (opcode)
                            OP_PERM:
                            begin
                                factor_next = n8;
                                steps_next  = r8;
                                fac_dn_next = 1'b1;
                            end
                            OP_POWER:
                            begin
                                factor_next = n8;
                                steps_next  = r8;
                            end
                            default:
                            begin
                                factor_next = m_sel - k_sel + 1'b1;
                                steps_next  = k_sel;
                                fac_up_next = 1'b1;
                                div_up_next = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_WAIT:
            begin
                if (md_rsp.done)
                begin
                    if (overflow)
                    begin
                        acc_next        = '1;
                        fin_status_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        acc_next   = md_rsp.quot[ACC_W-1:0];
                        steps_next = steps_reg - 1'b1;
                        if (fac_dn_reg)
                            factor_next = factor_reg - 1'b1;
                        else if (fac_up_reg)
                            factor_next = factor_reg + 1'b1;
                        if (div_up_reg)
                            divisor_next = divisor_reg + 1'b1;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    count_next     = acc_reg;
                    status_next    = fin_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg        <= acc_next;
        factor_reg     <= factor_next;
        divisor_reg    <= divisor_next;
        steps_reg      <= steps_next;
        fac_up_reg     <= fac_up_next;
        fac_dn_reg     <= fac_dn_next;
        div_up_reg     <= div_up_next;
        fin_status_reg <= fin_status_next;
        count_reg      <= count_next;
        status_reg     <= status_next;
    end

    assign out_valid = out_valid_reg;
    assign count     = count_reg;
    assign status    = status_reg;

endmodule

// File: design/ccu_muldiv.sv
`timescale 1ns / 1ps
// (acc * factor) / divisor: the product is loaded on start, then a radix-256 restoring
// divide, 8 quotient bits per cycle. Divisor is never zero.
module ccu_muldiv
(
    input  logic             clk,
    input  logic             rst_n,
    input  ccu_pkg::md_req_t req,
    output ccu_pkg::md_rsp_t rsp
);
    import ccu_pkg::*;

    localparam int DIGIT_W = 8;
    localparam int DIGITS  = PROD_W / DIGIT_W;
    localparam int CNT_W   = $clog2(DIGITS);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] sh_reg, sh_next;
    logic [FAC_W-1:0]  rem_reg, rem_next;
    logic [FAC_W-1:0]  div_reg, div_next;

    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] sh_step;
    logic [FAC_W-1:0]  rem_step;
    logic [FAC_W:0]    trial;

    assign prod = PROD_W'(req.acc) * PROD_W'(req.factor);

    // quotient bits shift in at the bottom as dividend bits leave the top
    always_comb
    begin
        sh_step  = sh_reg;
        rem_step = rem_reg;
        trial    = '0;
        for (int j = 0; j < DIGIT_W; j++)
        begin
            trial   = {rem_step, sh_step[PROD_W-1]};
            sh_step = {sh_step[PROD_W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg})
            begin
                trial      = trial - {1'b0, div_reg};
                sh_step[0] = 1'b1;
            end
            rem_step = trial[FAC_W-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            sh_next   = prod;
            rem_next  = '0;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            sh_next  = sh_step;
            rem_next = rem_step;
            if (cnt_reg == CNT_W'(DIGITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = sh_reg;

endmodule

// File: design/ccu_checker.sv
`timescale 1ns / 1ps
module ccu_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] count,
    input logic [1:0]  status
);
    import ccu_pkg::*;

    // a word is never taken while the previous one is still being counted
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken back to back");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_INVALID || status == ST_OVERFLOW))
        else $error("undefined status code");

    a_overflow_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OVERFLOW |-> &count)
        else $error("overflow word not saturated");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_INVALID |-> count == '0)
        else $error("invalid word has nonzero count");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(count) && $stable(status))
        else $error("output word changed while stalled");

endmodule

bind combinatorial_count_unit ccu_checker u_ccu_checker (.*);

// File: bench/tb_combinatorial_count_unit.sv
`timescale 1ns / 1ps
module tb_combinatorial_count_unit;
    import ccu_pkg::*;

    typedef struct {
        logic [6:0] n;
        logic [6:0] r;
        logic [1:0] op;
        bit         drain;  // hold this word until every answer is back
    } count_query_t;

    typedef struct {
        logic [6:0]  n;
        logic [6:0]  r;
        logic [1:0]  op;
        logic [63:0] count;
        logic [1:0]  status;
    } count_answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [6:0]  n_items = '0;
    logic [6:0]  r_chosen = '0;
    logic [1:0]  opcode = OP_PERM;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] count;
    logic [1:0]  status;

    count_query_t  query_q[$];
    count_answer_t answer_q[$];
    count_query_t  next_query;
    count_answer_t got_answer;
    int            in_gap = 0;
    int            in_burst = 0;
    int            out_stall = 0;
    int            out_burst = 0;
    int            errors = 0;

    combinatorial_count_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .n_items   (n_items),
        .r_chosen  (r_chosen),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .count     (count),
        .status    (status)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // acc *= f; leaves acc alone and returns 0 if the product needs more than 64 bits
    function automatic bit mul_fits(inout logic [63:0] acc, input logic [63:0] f);
        logic [127:0] prod;
        prod = {64'd0, acc} * {64'd0, f};
        if (prod[127:64] != '0)
            return 1'b0;
        acc = prod[63:0];
        return 1'b1;
    endfunction

    // C(m,k) one exact step at a time; gcd keeps each divide exact
    function automatic bit binom_fits(input logic [63:0] m, input logic [63:0] k,
                                      output logic [63:0] val);
        logic [63:0] acc;
        logic [63:0] kk;
        logic [63:0] idx;
        logic [63:0] g;
        logic [63:0] b;
        logic [63:0] t;
        logic [63:0] d;
        acc = 64'd1;
        kk = (k > m - k) ? m - k : k;
        val = '0;
        for (idx = 64'd1; idx <= kk; idx++)
        begin
            g = acc;
            b = idx;
            while (b != 0)
            begin
                t = g % b;
                g = b;
                b = t;
            end
            d = idx / g;
            acc = acc / g;
            if (!mul_fits(acc, (m - kk + idx) / d))
                return 1'b0;
        end
        val = acc;
        return 1'b1;
    endfunction

    function automatic count_answer_t predict_count(logic [6:0] n, logic [6:0] r,
                                                    logic [1:0] op);
        count_answer_t res;
        logic [63:0]   nn;
        logic [63:0]   rr;
        logic [63:0]   val;
        logic [63:0]   idx;
        bit            fits;
        res.n = n;
        res.r = r;
        res.op = op;
        res.count = '0;
        res.status = ST_INVALID;
        nn = {57'd0, n};
        rr = {57'd0, r};
        if (nn > CCU_MAX_N || rr > CCU_MAX_N || rr > nn)
            return res;
        val = 64'd1;
        fits = 1'b1;
        case (op)
            OP_PERM:
                for (idx = 0; idx < rr && fits; idx++)
                    fits = mul_fits(val, nn - idx);
            OP_POWER:
                for (idx = 0; idx < rr && fits; idx++)
                    fits = mul_fits(val, nn);
            OP_COMB:
                fits = binom_fits(nn, rr, val);
            default:
                if (nn == 0)
                    val = 64'd1;
                else
                    fits = binom_fits(nn + rr - 1, rr, val);
        endcase
        res.count = fits ? val : '1;
        res.status = fits ? ST_OK : ST_OVERFLOW;
        return res;
    endfunction

    // mostly short gaps, some long ones, and now and then a run with none
    function automatic int gap_len(inout int burst);
        int pick;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            burst = $urandom_range(10, 40);
            return 0;
        end
        if (pick < 50)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    task automatic add_query(int n, int r, logic [1:0] op, bit drain);
        count_query_t q;
        q.n = n[6:0];
        q.r = r[6:0];
        q.op = op;
        q.drain = drain;
        query_q.push_back(q);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!(in_valid && !in_ready))
        begin
            if (in_valid)
                answer_q.push_back(predict_count(n_items, r_chosen, opcode));
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (query_q.size() != 0 && !(query_q[0].drain && answer_q.size() != 0))
            begin
                next_query = query_q.pop_front();
                n_items <= next_query.n;
                r_chosen <= next_query.r;
                opcode <= next_query.op;
                in_valid <= 1'b1;
                in_gap = gap_len(in_burst);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (answer_q.size() == 0)
                begin
                    $display("%0t: unexpected word, count %0d status %0d", $time, count, status);
                    errors++;
                end
                else
                begin
                    got_answer = answer_q.pop_front();
                    if (count !== got_answer.count)
                    begin
                        $display("%0t: count mismatch n=%0d r=%0d op=%0d: expected %0d, got %0d",
                                 $time, got_answer.n, got_answer.r, got_answer.op,
                                 got_answer.count, count);
                        errors++;
                    end
                    if (status !== got_answer.status)
                    begin
                        $display("%0t: status mismatch n=%0d r=%0d op=%0d: expected %0d, got %0d",
                                 $time, got_answer.n, got_answer.r, got_answer.op,
                                 got_answer.status, status);
                        errors++;
                    end
                end
                out_stall = gap_len(out_burst);
            end
            if (out_stall > 0)
            begin
                out_stall--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int pick;
        int n;
        int r;
        logic [1:0] op;

        // zero choices from the empty set, then full choices from the largest set
        add_query(0, 0, OP_PERM, 1'b0);
        add_query(0, 0, OP_POWER, 1'b0);
        add_query(0, 0, OP_COMB, 1'b0);
        add_query(0, 0, OP_MULTISET, 1'b0);
        add_query(64, 64, OP_PERM, 1'b0);
        add_query(64, 64, OP_POWER, 1'b0);
        add_query(64, 64, OP_COMB, 1'b0);
        add_query(64, 64, OP_MULTISET, 1'b0);
        // invalid: r above n (repeat op too), n or r above the limit
        add_query(5, 7, OP_MULTISET, 1'b0);
        add_query(127, 0, OP_PERM, 1'b0);
        add_query(127, 127, OP_POWER, 1'b0);
        add_query(0, 127, OP_COMB, 1'b0);
        add_query(65, 3, OP_COMB, 1'b0);
        // right at the 64-bit edge, then small folded and trivial binomials
        add_query(20, 20, OP_PERM, 1'b0);
        add_query(21, 21, OP_PERM, 1'b0);
        add_query(2, 63, OP_POWER, 1'b0);
        add_query(2, 64, OP_POWER, 1'b0);
        add_query(64, 32, OP_COMB, 1'b0);
        add_query(34, 33, OP_MULTISET, 1'b0);
        add_query(35, 34, OP_MULTISET, 1'b0);
        add_query(64, 63, OP_COMB, 1'b0);
        add_query(1, 1, OP_MULTISET, 1'b0);
        add_query(64, 0, OP_MULTISET, 1'b0);

        for (int i = 0; i < 420; i++)
        begin
            pick = $urandom_range(0, 99);
            op = 2'($urandom_range(0, 3));
            if (pick < 85)
            begin
                n = $urandom_range(0, CCU_MAX_N);
                r = $urandom_range(0, n);
            end
            else if (pick < 91)
            begin
                n = $urandom_range(0, CCU_MAX_N);
                r = $urandom_range(n + 1, 127);
            end
            else if (pick < 96)
            begin
                n = $urandom_range(CCU_MAX_N + 1, 127);
                r = $urandom_range(0, 127);
            end
            else
            begin
                n = $urandom_range(0, 127);
                r = $urandom_range(0, 127);
            end
            add_query(n, r, op, i == 0 || i == 210);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (query_q.size() != 0 || in_valid || answer_q.size() != 0);
        repeat (750) @(posedge clk);

        if (errors == 0 && answer_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
design/ccu_pkg.sv
design/ccu_muldiv.sv
design/combinatorial_count_unit.sv
design/ccu_checker.sv
bench/tb_combinatorial_count_unit.sv
